[sv/swfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swfr_pkg;

	localparam logic [7:0]  FRAME_MARKER   = 8'hA5;
	localparam logic [7:0]  LINE_FEED      = 8'h0A;
	localparam logic [20:0] OVERFLOW_SLACK = 21'd2048;
	localparam logic [20:0] PENDING_MAX    = 21'h1FFFFF;
	localparam logic [19:0] MAX_LINE_RESET = 20'd34816;
	localparam int          QUEUE_DEPTH_DEFAULT = 4;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_LINE_END = 2'd1,
		KIND_ACK      = 2'd2,
		KIND_OVERFLOW = 2'd3
	} swfr_kind_t;

	// all results caused by one input byte, in output order a, b, c
	typedef struct packed {
		logic        a_valid;
		swfr_kind_t  a_kind;
		logic [7:0]  a_data;
		logic [15:0] a_seq;
		logic        b_valid;   // frame end acknowledge
		logic [15:0] b_seq;
		logic        c_valid;   // overflow discard
	} swfr_bundle_t;

endpackage

`default_nettype wire

[sv/swfr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module swfr_front import swfr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_accept,
	input  wire logic         action,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         frame_end,
	input  wire logic         cfg_write,
	input  wire logic [19:0]  cfg_value,
	output logic              push,
	output swfr_bundle_t      bundle
);

	typedef enum logic [1:0] {
		POS_MARKER  = 2'd0,
		POS_SEQ_LO  = 2'd1,
		POS_SEQ_HI  = 2'd2,
		POS_PAYLOAD = 2'd3
	} pos_t;

	typedef enum logic [1:0] {
		V_UNDECIDED = 2'd0,
		V_ACCEPT    = 2'd1,
		V_IGNORE    = 2'd2
	} verdict_t;

	logic [20:0] limit_q;
	logic [15:0] expected_q, completed_q;
	logic        completed_valid_q;
	pos_t        pos_q;
	logic [7:0]  seq_low_q;
	verdict_t    verdict_q;
	logic        had_nl_q;
	logic [20:0] pending_q;

	logic [15:0]  exp_d, comp_d;
	logic         cv_d;
	pos_t         pos_d;
	logic [7:0]   low_d;
	verdict_t     verdict_d;
	logic         nl_d;
	logic [20:0]  pend_d;
	logic [15:0]  hdr_seq;
	swfr_bundle_t bun;

	assign hdr_seq = {rx_byte, seq_low_q};

	always_comb begin
		exp_d     = expected_q;
		comp_d    = completed_q;
		cv_d      = completed_valid_q;
		pos_d     = pos_q;
		low_d     = seq_low_q;
		verdict_d = verdict_q;
		nl_d      = had_nl_q;
		pend_d    = pending_q;
		bun       = '0;
		bun.a_kind = KIND_BYTE;
		case (pos_q)
			POS_MARKER: begin
				if (rx_byte != FRAME_MARKER)
					verdict_d = V_IGNORE;
				pos_d = POS_SEQ_LO;
			end
			POS_SEQ_LO: begin
				low_d = rx_byte;
				pos_d = POS_SEQ_HI;
			end
			POS_SEQ_HI: begin
				if (verdict_q == V_UNDECIDED) begin
					// repeat of the line's final frame, or an older duplicate
					if ((completed_valid_q && expected_q == '0 && hdr_seq == completed_q)
					    || hdr_seq < expected_q) begin
						bun.a_valid = 1'b1;
						bun.a_kind  = KIND_ACK;
						bun.a_seq   = hdr_seq;
						verdict_d   = V_IGNORE;
					end else if (hdr_seq > expected_q) begin
						verdict_d = V_IGNORE;
					end else begin
						if (hdr_seq == '0)
							cv_d = 1'b0;
						verdict_d = V_ACCEPT;
					end
				end
				pos_d = POS_PAYLOAD;
			end
			default: begin
				if (verdict_q == V_ACCEPT) begin
					bun.a_valid = 1'b1;
					if (rx_byte == LINE_FEED) begin
						bun.a_kind = KIND_LINE_END;
						pend_d = '0;
						nl_d   = 1'b1;
					end else begin
						bun.a_kind = KIND_BYTE;
						bun.a_data = rx_byte;
						if (pending_q != PENDING_MAX)
							pend_d = pending_q + 21'd1;
					end
				end
			end
		endcase
		if (frame_end) begin
			if (verdict_d == V_ACCEPT && pos_d == POS_PAYLOAD) begin
				bun.b_valid = 1'b1;
				bun.b_seq   = expected_q;
				if (nl_d) begin
					comp_d = expected_q;
					cv_d   = 1'b1;
					exp_d  = '0;
				end else begin
					exp_d = expected_q + 16'd1;
				end
				if (pend_d > limit_q) begin
					bun.c_valid = 1'b1;
					pend_d = '0;
					exp_d  = '0;
					cv_d   = 1'b0;
				end
			end
			pos_d     = POS_MARKER;
			verdict_d = V_UNDECIDED;
			nl_d      = 1'b0;
		end
	end

	assign push   = in_accept && !action && (bun.a_valid || bun.b_valid || bun.c_valid);
	assign bundle = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q           <= {1'b0, MAX_LINE_RESET} + OVERFLOW_SLACK;
			expected_q        <= '0;
			completed_q       <= '0;
			completed_valid_q <= 1'b0;
			pos_q             <= POS_MARKER;
			seq_low_q         <= '0;
			verdict_q         <= V_UNDECIDED;
			had_nl_q          <= 1'b0;
			pending_q         <= '0;
		end else begin
			// limit is kept with the slack already added
			if (cfg_write)
				limit_q <= {1'b0, cfg_value} + OVERFLOW_SLACK;
			if (in_accept) begin
				if (action) begin
					expected_q        <= '0;
					completed_q       <= '0;
					completed_valid_q <= 1'b0;
					pos_q             <= POS_MARKER;
					seq_low_q         <= '0;
					verdict_q         <= V_UNDECIDED;
					had_nl_q          <= 1'b0;
					pending_q         <= '0;
				end else begin
					expected_q        <= exp_d;
					completed_q       <= comp_d;
					completed_valid_q <= cv_d;
					pos_q             <= pos_d;
					seq_low_q         <= low_d;
					verdict_q         <= verdict_d;
					had_nl_q          <= nl_d;
					pending_q         <= pend_d;
				end
			end
		end
	end

endmodule

`default_nettype wire

[sv/swfr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module swfr_queue import swfr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  swfr_bundle_t       push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output swfr_bundle_t       head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	swfr_bundle_t  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

[sv/swfr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module swfr_back import swfr_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  swfr_bundle_t       head,
	output logic               pop,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [23:0]        m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);

	logic [2:0]  done_q;
	logic        out_valid_q;
	swfr_kind_t  out_kind_q;
	logic [7:0]  out_data_q;
	logic [15:0] out_seq_q;
	logic        out_last_q;

	logic [2:0]  mask, rem, sel;
	logic        load, sel_last;

	assign mask = {head.c_valid, head.b_valid, head.a_valid};
	assign rem  = mask & ~done_q;
	assign sel  = rem[0] ? 3'b001 : (rem[1] ? 3'b010 : 3'b100);
	assign sel_last = ((rem & ~sel) == 3'b000);
	assign load = head_valid && (!out_valid_q || m_tready);
	assign pop  = load && sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= sel_last ? 3'b000 : (done_q | sel);
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_last_q <= sel_last;
			if (sel[0]) begin
				out_kind_q <= head.a_kind;
				out_data_q <= head.a_data;
				out_seq_q  <= head.a_seq;
			end else if (sel[1]) begin
				out_kind_q <= KIND_ACK;
				out_data_q <= '0;
				out_seq_q  <= head.b_seq;
			end else begin
				out_kind_q <= KIND_OVERFLOW;
				out_data_q <= '0;
				out_seq_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_seq_q, out_data_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (mask != 3'b000))
		else $error("queued bundle carries no result");

	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ((done_q & ~mask) == 3'b000))
		else $error("done mask marks a slot the bundle lacks");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (done_q == 3'b000))
		else $error("partial progress held without a bundle");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && out_last_q))
		else $error("bundle retired without a last result");

endmodule

`default_nettype wire

[sv/stop_and_wait_frame_receiver.sv]
// path: a result passes through the queue and then the output register to m_tdata
// throughput: one byte per cycle while the queue is not full; the back end sends one
// result per cycle while m_tready is high, so the up to three results of a frame end byte
// are absorbed by a queue of QUEUE_DEPTH result groups that stalls s_tready only when full
// reset: arst_n clears all frame state, the queue and the output register, and
// sets max_line_bytes to 34816; the block is ready as soon as arst_n is released
`timescale 1ns / 1ps
`default_nettype none

module stop_and_wait_frame_receiver import swfr_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // rx_byte
	input  wire logic         s_tuser,   // action
	input  wire logic         s_tlast,   // frame_end
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [23:0]       m_tdata,   // data [7:0], ack_sequence [23:8]
	output logic [1:0]        m_tuser,   // kind
	output logic              m_tlast,   // last
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [19:0]  cfg_data   // max_line_bytes
);

	logic         push, full, pop, head_valid, in_accept;
	swfr_bundle_t push_data, head;

	assign s_tready  = !full;
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	swfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.action    (s_tuser),
		.rx_byte   (s_tdata),
		.frame_end (s_tlast),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_value (cfg_data),
		.push      (push),
		.bundle    (push_data)
	);

	swfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	swfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

[test/swfr_checker.sv]
`timescale 1ns / 1ps

module swfr_checker import swfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tuser,   // action
	input  logic        s_tlast,   // frame_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // data [7:0], ack_sequence [23:8]
	input  logic [1:0]  m_tuser,   // kind
	input  logic        m_tlast,   // last
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [19:0] cfg_data,  // max_line_bytes
	output int          n_fail,
	output int          n_waiting
);

	typedef enum logic [1:0] {
		POS_MARKER,
		POS_SEQ_LO,
		POS_SEQ_HI,
		POS_PAYLOAD
	} frame_pos_t;

	typedef enum logic [1:0] {
		FRAME_UNDECIDED,
		FRAME_ACCEPTED,
		FRAME_IGNORED
	} frame_verdict_t;

	typedef struct {
		swfr_kind_t  kind;
		logic [7:0]  data;
		logic [15:0] seq;
		logic        last;
	} rx_result_t;

	logic [19:0]    line_limit;
	logic [15:0]    expected_seq;
	logic [15:0]    done_seq;
	logic           done_valid;
	frame_pos_t     pos;
	logic [7:0]     seq_lo;
	frame_verdict_t verdict;
	logic           had_line_feed;
	logic [20:0]    line_bytes;
	rx_result_t     byte_results[$];
	rx_result_t     awaited_results[$];
	rx_result_t     oldest;

	function automatic void clear_link();
		expected_seq = '0;
		done_seq = '0;
		done_valid = 1'b0;
		pos = POS_MARKER;
		seq_lo = '0;
		verdict = FRAME_UNDECIDED;
		had_line_feed = 1'b0;
		line_bytes = '0;
	endfunction

	function automatic void add_result(input swfr_kind_t kind, input logic [7:0] data,
			input logic [15:0] seq);
		rx_result_t r;
		r.kind = kind;
		r.data = data;
		r.seq = seq;
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void predict_byte_results(input logic link_event, input logic [7:0] rx,
			input logic frame_end);
		logic [15:0] seq;
		byte_results.delete();
		if (link_event) begin
			clear_link();
			return;
		end
		case (pos)
			POS_MARKER: begin
				if (rx != FRAME_MARKER)
					verdict = FRAME_IGNORED;
				pos = POS_SEQ_LO;
			end
			POS_SEQ_LO: begin
				seq_lo = rx;
				pos = POS_SEQ_HI;
			end
			POS_SEQ_HI: begin
				if (verdict == FRAME_UNDECIDED) begin
					seq = {rx, seq_lo};
					// repeat of the frame that closed the last line, or an older frame
					if ((done_valid && expected_seq == 16'd0 && seq == done_seq) ||
							seq < expected_seq) begin
						add_result(KIND_ACK, 8'h00, seq);
						verdict = FRAME_IGNORED;
					end else if (seq > expected_seq) begin
						verdict = FRAME_IGNORED;
					end else begin
						if (seq == 16'd0)
							done_valid = 1'b0;
						verdict = FRAME_ACCEPTED;
					end
				end
				pos = POS_PAYLOAD;
			end
			default: begin
				if (verdict == FRAME_ACCEPTED) begin
					if (rx == LINE_FEED) begin
						add_result(KIND_LINE_END, 8'h00, 16'h0000);
						line_bytes = '0;
						had_line_feed = 1'b1;
					end else begin
						add_result(KIND_BYTE, rx, 16'h0000);
						if (line_bytes != PENDING_MAX)
							line_bytes = line_bytes + 21'd1;
					end
				end
			end
		endcase

		if (frame_end) begin
			// header-only frames reach the payload position on their last byte too
			if (verdict == FRAME_ACCEPTED && pos == POS_PAYLOAD) begin
				seq = expected_seq;
				add_result(KIND_ACK, 8'h00, seq);
				if (had_line_feed) begin
					done_seq = seq;
					done_valid = 1'b1;
					expected_seq = '0;
				end else begin
					expected_seq = seq + 16'd1;
				end
				if (line_bytes > ({1'b0, line_limit} + OVERFLOW_SLACK)) begin
					add_result(KIND_OVERFLOW, 8'h00, 16'h0000);
					line_bytes = '0;
					expected_seq = '0;
					done_valid = 1'b0;
				end
			end
			pos = POS_MARKER;
			verdict = FRAME_UNDECIDED;
			had_line_feed = 1'b0;
		end

		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i])
			awaited_results.push_back(byte_results[i]);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (n_fail < 40)
			$display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_link();
			line_limit = MAX_LINE_RESET;
			awaited_results.delete();
			n_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				line_limit = cfg_data;
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result, kind", 32'(m_tuser), 32'h0);
				end else begin
					oldest = awaited_results.pop_front();
					if (m_tuser !== oldest.kind)
						report_mismatch("kind", 32'(m_tuser), 32'(oldest.kind));
					if (m_tdata[7:0] !== oldest.data)
						report_mismatch("data", 32'(m_tdata[7:0]), 32'(oldest.data));
					if (m_tdata[23:8] !== oldest.seq)
						report_mismatch("ack_sequence", 32'(m_tdata[23:8]), 32'(oldest.seq));
					if (m_tlast !== oldest.last)
						report_mismatch("last", 32'(m_tlast), 32'(oldest.last));
				end
			end
			if (s_tvalid && s_tready)
				predict_byte_results(s_tuser, s_tdata, s_tlast);
			n_waiting <= awaited_results.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import swfr_pkg::*;

	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int SETTLE_CYCLES = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [19:0] cfg_data = '0;
	int          n_fail;
	int          n_waiting;
	int          cycle_count = 0;
	int          sent_items = 0;
	int          stall_left = 0;
	logic        source_gaps = 1'b0;
	logic        sink_stalls = 1'b0;
	logic [15:0] tx_seq = '0;
	logic [15:0] line_seq = '0;
	logic        line_seq_valid = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stop_and_wait_frame_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	swfr_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.n_fail    (n_fail),
		.n_waiting (n_waiting)
	);

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (!sink_stalls) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 20) begin
			m_tready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_byte(input logic link_event, input logic [7:0] b, input logic ends_frame);
		int gap;
		gap = source_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= link_event;
		s_tdata <= b;
		s_tlast <= ends_frame;
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	task automatic push_header(input logic [7:0] mark, input logic [15:0] seq,
			input logic ends_here);
		push_byte(1'b0, mark, 1'b0);
		push_byte(1'b0, seq[7:0], 1'b0);
		push_byte(1'b0, seq[15:8], ends_here);
	endtask

	task automatic send_frame(input logic [7:0] mark, input logic [15:0] seq, input int n_payload,
			input int lf_pct, output logic had_lf);
		logic [7:0] b;
		had_lf = 1'b0;
		push_header(mark, seq, n_payload == 0);
		for (int i = 0; i < n_payload; i++) begin
			b = 8'($urandom);
			if (b == LINE_FEED)
				b = 8'h0B;
			if ($urandom_range(0, 99) < lf_pct)
				b = LINE_FEED;
			had_lf |= (b == LINE_FEED);
			push_byte(1'b0, b, i == n_payload - 1);
		end
	endtask

	task automatic drop_link();
		push_byte(1'b1, 8'($urandom), 1'($urandom));
		tx_seq = '0;
		line_seq_valid = 1'b0;
	endtask

	function automatic int payload_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
	endfunction

	// in-order frame from the sender's point of view
	task automatic send_next_frame();
		logic had_lf;
		send_frame(FRAME_MARKER, tx_seq, payload_len(), 15, had_lf);
		if (had_lf) begin
			line_seq = tx_seq;
			line_seq_valid = 1'b1;
			tx_seq = '0;
		end else begin
			tx_seq = tx_seq + 16'd1;
		end
	endtask

	task automatic random_traffic(input int n_items);
		int stop_at;
		int r;
		int k;
		logic had_lf;
		logic [7:0] mark;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 55 || (r < 62 && !line_seq_valid) || (r >= 62 && r < 70 && tx_seq == 0)) begin
				send_next_frame();
			end else if (r < 62) begin
				send_frame(FRAME_MARKER, line_seq, payload_len(), 15, had_lf);
			end else if (r < 70) begin
				send_frame(FRAME_MARKER, 16'($urandom_range(0, tx_seq - 1)), payload_len(), 15,
						had_lf);
			end else if (r < 75) begin
				send_frame(FRAME_MARKER, tx_seq + 16'($urandom_range(1, 4)), payload_len(), 15,
						had_lf);
			end else if (r < 79) begin
				send_frame(FRAME_MARKER, 16'($urandom), payload_len(), 15, had_lf);
			end else if (r < 84) begin
				mark = 8'($urandom);
				if (mark == FRAME_MARKER)
					mark = ~mark;
				send_frame(mark, tx_seq, payload_len(), 15, had_lf);
			end else if (r < 90) begin
				// frame cut inside its header
				k = $urandom_range(1, 2);
				push_byte(1'b0, $urandom_range(0, 1) ? FRAME_MARKER : 8'($urandom), k == 1);
				if (k == 2)
					push_byte(1'b0, 8'($urandom), 1'b1);
			end else if (r < 95) begin
				k = $urandom_range(1, 5);
				push_byte(1'b0, FRAME_MARKER, 1'b0);
				if (k >= 2)
					push_byte(1'b0, tx_seq[7:0], 1'b0);
				if (k >= 3)
					push_byte(1'b0, tx_seq[15:8], 1'b0);
				for (int i = 3; i < k; i++)
					push_byte(1'b0, 8'($urandom), 1'b0);
				drop_link();
			end else begin
				drop_link();
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (n_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_line(input logic [19:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header-only accept of sequence zero, then a line closed by frame 1
		push_header(FRAME_MARKER, 16'd0, 1'b1);
		push_header(FRAME_MARKER, 16'd1, 1'b0);
		push_byte(1'b0, 8'hFF, 1'b0);
		push_byte(1'b0, LINE_FEED, 1'b1);
		// repeat of the line's final frame is acked again
		push_header(FRAME_MARKER, 16'd1, 1'b1);
		push_header(FRAME_MARKER, 16'd0, 1'b0);
		push_byte(1'b0, 8'h00, 1'b1);
		// duplicate, too far ahead, bad marker
		push_header(FRAME_MARKER, 16'd0, 1'b1);
		push_header(FRAME_MARKER, 16'hFFFF, 1'b1);
		push_header(8'h5A, 16'd1, 1'b1);
		push_byte(1'b0, FRAME_MARKER, 1'b1);
		// link event in the middle of a frame
		push_byte(1'b0, FRAME_MARKER, 1'b0);
		push_byte(1'b0, 8'h01, 1'b0);
		push_byte(1'b1, FRAME_MARKER, 1'b1);
		tx_seq = '0;
		line_seq_valid = 1'b0;
		settle();

		random_traffic(50);
		source_gaps = 1'b1;
		sink_stalls <= 1'b1;
		random_traffic(50);

		write_max_line(20'hFFFFF);
		random_traffic(50);

		write_max_line(20'd0);
		drop_link();
		random_traffic(30);

		write_max_line(20'($urandom_range(1, 20'hFFFFE)));
		random_traffic(40);
		settle();

		if (n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
